FILE: hdl/pdrq_pkg.sv
// Package for the packet descriptor ring queue.
// Holds the sizes, the command and result word types, the action and register codes
// and the ring index helpers. It depends on nothing else.
package pdrq_pkg;

	localparam int SLOTS  = 256;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int PRIO_W = 4;
	localparam int SEQ_W  = 32;
	localparam int CNT_W  = 8;
	localparam int POS_W  = 8;
	localparam int ACT_W  = 3;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [SEQ_W-1:0]  SEQ_WILDCARD = '1;
	localparam logic [PRIO_W-1:0] PRIO_EMPTY   = '0;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_LOOKUP = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	// Register index, taken from the word address bit of the configuration port.
	typedef enum logic {
		REG_OVERWRITE = 1'b0,
		REG_CAPACITY  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PRIO_W-1:0] priority_req;
		logic [SEQ_W-1:0]  sequence_req;
		logic              sent_flag;
		logic [POS_W-1:0]  position;
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic              overwrote;
		logic [CNT_W-1:0]  count;
		logic              has_unsent;
		logic [PRIO_W-1:0] highest_priority;
		logic [SEQ_W-1:0]  first_sent_sequence;
		logic [SEQ_W-1:0]  last_sequence;
		logic [PRIO_W-1:0] entry_priority;
		logic [SEQ_W-1:0]  entry_sequence;
		logic              entry_sent;
	} result_t;

	typedef struct packed {
		logic              sent;
		logic [SEQ_W-1:0]  seq;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             overwrite_enable;
		logic [CNT_W-1:0] capacity;
	} cfg_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic             init;
		logic             ok_init;
		logic             over_init;
		logic             lookup_en;
		logic             read_en;
		logic [POS_W-1:0] read_pos;
		logic [CNT_W-1:0] count;
		logic [SEQ_W-1:0] seq_req;
	} scan_ctl_t;

	// Ring index that lies off places after idx, wrapped at the slot count.
	function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, idx} + {1'b0, off};
		if (s >= (IDX_W+1)'(SLOTS)) begin
			s = s - (IDX_W+1)'(SLOTS);
		end
		return s[IDX_W-1:0];
	endfunction

	// Capacity as the queue uses it: at least one, at most one less than the slots.
	function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] c;
		c = cap;
		if (c == '0) begin
			c = CNT_W'(1);
		end
		if ({1'b0, c} > (CNT_W+1)'(SLOTS - 1)) begin
			c = CNT_W'(SLOTS - 1);
		end
		return c;
	endfunction

endpackage

FILE: hdl/pdrq_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing else.
module pdrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/pdrq_cfg.sv
// Configuration registers of the ring queue behind an APB-style port.
// Depends on pdrq_pkg.
module pdrq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdrq_pkg::CFG_AW-1:0]   paddr,
	input  logic [pdrq_pkg::CFG_DW-1:0]   pwdata,
	output logic [pdrq_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	output pdrq_pkg::cfg_t                cfg
);
	import pdrq_pkg::*;

	logic             overwrite_q;
	logic [CNT_W-1:0] capacity_q;
	logic             wr_en;
	reg_idx_t         reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overwrite_q <= 1'b1;
			capacity_q  <= CNT_W'(255);
		end else if (wr_en) begin
			case (reg_sel)
				REG_OVERWRITE: overwrite_q <= pwdata[0];
				REG_CAPACITY:  capacity_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_OVERWRITE: prdata = {{(CFG_DW-1){1'b0}}, overwrite_q};
			REG_CAPACITY:  prdata = {{(CFG_DW-CNT_W){1'b0}}, capacity_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.overwrite_enable = overwrite_q;
	assign cfg.capacity         = capacity_q;

endmodule

FILE: hdl/pdrq_scan.sv
// Scan unit: one compare and maximum stage that folds the queue entries, one per cycle,
// into the status, lookup and read fields of the result word. Depends on pdrq_pkg.
module pdrq_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdrq_pkg::scan_ctl_t           ctl,
	input  logic                          ent_vld,
	input  logic [pdrq_pkg::IDX_W-1:0]    ent_pos,
	input  pdrq_pkg::entry_t              ent,
	output pdrq_pkg::result_t             res
);
	import pdrq_pkg::*;

	logic              lookup_en_q;
	logic              lookup_done_q;
	logic              read_en_q;
	logic [POS_W-1:0]  read_pos_q;
	logic [SEQ_W-1:0]  seq_req_q;
	result_t           res_q;
	logic              seq_match;
	logic [CNT_W-1:0]  pos_ext;

	assign pos_ext   = CNT_W'(ent_pos);
	assign seq_match = (seq_req_q == SEQ_WILDCARD) || (ent.seq == SEQ_WILDCARD) ||
		(ent.seq == seq_req_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_en_q   <= 1'b0;
			lookup_done_q <= 1'b0;
			read_en_q     <= 1'b0;
		end else if (ctl.init) begin
			lookup_en_q   <= ctl.lookup_en;
			lookup_done_q <= 1'b0;
			read_en_q     <= ctl.read_en;
		end else if (ent_vld && lookup_en_q && !lookup_done_q) begin
			// The lookup stops at the first unsent entry or at the first match.
			if (!ent.sent || seq_match) begin
				lookup_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			read_pos_q                <= ctl.read_pos;
			seq_req_q                 <= ctl.seq_req;
			res_q.ok                  <= ctl.ok_init;
			res_q.overwrote           <= ctl.over_init;
			res_q.count               <= ctl.count;
			res_q.has_unsent          <= 1'b0;
			res_q.highest_priority    <= PRIO_EMPTY;
			res_q.first_sent_sequence <= SEQ_WILDCARD;
			res_q.last_sequence       <= SEQ_WILDCARD;
			res_q.entry_priority      <= '0;
			res_q.entry_sequence      <= '0;
			res_q.entry_sent          <= 1'b0;
		end else if (ent_vld) begin
			if (!ent.sent) begin
				res_q.has_unsent <= 1'b1;
			end
			if (ent.prio > res_q.highest_priority) begin
				res_q.highest_priority <= ent.prio;
			end
			if (pos_ext == '0) begin
				res_q.first_sent_sequence <= ent.sent ? ent.seq : SEQ_WILDCARD;
			end
			if (pos_ext == res_q.count - CNT_W'(1)) begin
				res_q.last_sequence <= ent.seq;
			end
			if (lookup_en_q && !lookup_done_q && ent.sent && seq_match) begin
				res_q.ok <= 1'b1;
			end
			if (read_en_q && pos_ext == read_pos_q) begin
				res_q.ok             <= 1'b1;
				res_q.entry_priority <= ent.prio;
				res_q.entry_sequence <= ent.seq;
				res_q.entry_sent     <= ent.sent;
			end
		end
	end

	assign res = res_q;

endmodule

FILE: hdl/packet_descriptor_ring_queue.sv
// Top level of the packet descriptor ring queue: command sequencer, descriptor memory,
// scan unit and configuration registers. Depends on pdrq_pkg, pdrq_ram, pdrq_cfg, pdrq_scan.
//
// A command word is taken at a clock edge where start is high and busy is low; busy then
// stays high until the result word has been shown. The execute state carries out the
// action on the ring pointers (and writes the pushed descriptor into the memory); the
// scan state then walks over all queued entries through the single read port of the
// descriptor memory, one entry per cycle, which the scan unit folds into the status
// fields, the lookup answer and the entry read. The result word is on the result port for
// exactly one cycle, marked by done, and the receiver cannot hold it off; busy drops in the
// cycle after done. Only entries inside the queue are ever read, so the memory needs no
// clearing after reset, and a clear command is a pointer reset. Configuration (overwrite
// enable and capacity) must be written through the APB-style port only while no command is
// in flight; the block itself does not enforce this. A clear leaves the configuration alone.
module packet_descriptor_ring_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pdrq_pkg::cmd_t                cmd,
	output logic                          done,
	output pdrq_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdrq_pkg::CFG_AW-1:0]   paddr,
	input  logic [pdrq_pkg::CFG_DW-1:0]   pwdata,
	output logic [pdrq_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);
	import pdrq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	cfg_t              cfg;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_pos_s1;

	// Action decode, valid in the execute cycle.
	logic              is_push;
	logic              is_pop;
	logic              is_clear;
	logic              full;
	logic              drop;
	logic              room;
	logic              pop_ok;
	logic [IDX_W-1:0]  head_d;
	logic [IDX_W-1:0]  tail_d;
	logic [CNT_W-1:0]  count_d;

	logic              mem_we;
	entry_t            mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;
	logic [ENTRY_W-1:0] mem_rbits;
	logic              issue;
	scan_ctl_t         scan_ctl;

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
	end

	assign is_push  = (cmd_q.action == ACT_PUSH);
	assign is_pop   = (cmd_q.action == ACT_POP);
	assign is_clear = (cmd_q.action == ACT_CLEAR);
	assign full     = (count_q >= eff_capacity(cfg.capacity));
	// A push into a full queue either drops the oldest entry or is discarded.
	assign drop     = is_push && full && cfg.overwrite_enable && (count_q != '0);
	assign room     = is_push && (!full || drop);
	assign pop_ok   = is_pop && (count_q != '0);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		if (is_clear) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
		end else if (room) begin
			tail_d = slot_after(tail_q, IDX_W'(1));
			if (drop) begin
				head_d = slot_after(head_q, IDX_W'(1));
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (pop_ok) begin
			head_d  = slot_after(head_q, IDX_W'(1));
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					head_q    <= head_d;
					tail_q    <= tail_d;
					count_q   <= count_d;
					rd_cnt_q  <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// One memory read is issued per cycle until every queued entry has been visited.
	assign issue     = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
	assign mem_raddr = slot_after(head_q, IDX_W'(rd_cnt_q));

	always_ff @(posedge clk) begin
		rd_pos_s1 <= IDX_W'(rd_cnt_q);
	end

	assign mem_we          = (state_q == ST_EXEC) && room;
	assign mem_wdata.sent  = cmd_q.sent_flag;
	assign mem_wdata.seq   = cmd_q.sequence_req;
	assign mem_wdata.prio  = cmd_q.priority_req;
	assign mem_rdata       = entry_t'(mem_rbits);

	pdrq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rbits)
	);

	assign scan_ctl.init      = (state_q == ST_EXEC);
	assign scan_ctl.ok_init   = room || pop_ok;
	assign scan_ctl.over_init = drop;
	assign scan_ctl.lookup_en = (cmd_q.action == ACT_LOOKUP);
	assign scan_ctl.read_en   = (cmd_q.action == ACT_READ);
	assign scan_ctl.read_pos  = cmd_q.position;
	assign scan_ctl.count     = count_d;
	assign scan_ctl.seq_req   = cmd_q.sequence_req;

	pdrq_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.ent_vld (rd_vld_s1),
		.ent_pos (rd_pos_s1),
		.ent     (mem_rdata),
		.res     (result)
	);

	pdrq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

`ifndef SYNTHESIS
	// The tail always sits count places after the head.
	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == slot_after(head_q, IDX_W'(count_q)))
		else $error("ring pointers and entry count disagree");

	// The result strobe lasts exactly one cycle and the block is free right after it.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// The scan never reads past the queued entries.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(rd_pos_s1) < count_q))
		else $error("scan read beyond the queued entries");

	// An accepted push always leaves at least one entry behind.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q.action == ACT_PUSH && result.ok) |-> (result.count != '0))
		else $error("accepted push left an empty queue");
`endif

endmodule
